// ===== rtl/core/ifed_pkg.sv =====
`default_nettype none
package ifed_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 5;
    localparam int unsigned ShW   = 5;

    typedef enum logic [OpW-1:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_AND = 5'd3,
        OP_OR  = 5'd4,
        OP_XOR = 5'd5,
        OP_SHL = 5'd6,
        OP_SHR = 5'd7,
        OP_SRA = 5'd8,
        OP_EQ  = 5'd9,
        OP_NE  = 5'd10,
        OP_ULT = 5'd11,
        OP_ULE = 5'd12,
        OP_UGT = 5'd13,
        OP_UGE = 5'd14,
        OP_SLT = 5'd15,
        OP_SLE = 5'd16,
        OP_SGT = 5'd17,
        OP_SGE = 5'd18,
        OP_DIV = 5'd19,
        OP_REM = 5'd20
    } op_t;

    // Sideband that rides along the divider stages
    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [WordW-1:0] fast;
        logic             qneg;
        logic             rneg;
        logic             dz;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/ifed_fast.sv =====
`default_nettype none
module ifed_fast (
    input  wire logic [ifed_pkg::OpW-1:0]   op,
    input  wire logic [ifed_pkg::WordW-1:0] a,
    input  wire logic [ifed_pkg::WordW-1:0] b,
    output logic      [ifed_pkg::WordW-1:0] y
);
    import ifed_pkg::*;

    logic [ShW-1:0]   sh;
    logic [WordW-1:0] sa;
    logic [WordW-1:0] sb;

    assign sh = b[ShW-1:0];
    assign sa = a ^ {1'b1, {(WordW-1){1'b0}}};
    assign sb = b ^ {1'b1, {(WordW-1){1'b0}}};

    // Evaluate every operation except divide and remainder, which come later
    always_comb
    begin
        case (op)
            OP_ADD:  y = a + b;
            OP_SUB:  y = a - b;
            OP_MUL:  y = a * b;
            OP_AND:  y = a & b;
            OP_OR:   y = a | b;
            OP_XOR:  y = a ^ b;
            OP_SHL:  y = a << sh;
            OP_SHR:  y = a >> sh;
            OP_SRA:  y = WordW'($signed(a) >>> sh);
            OP_EQ:   y = WordW'(a == b);
            OP_NE:   y = WordW'(a != b);
            OP_ULT:  y = WordW'(a < b);
            OP_ULE:  y = WordW'(a <= b);
            OP_UGT:  y = WordW'(a > b);
            OP_UGE:  y = WordW'(a >= b);
            OP_SLT:  y = WordW'(sa < sb);
            OP_SLE:  y = WordW'(sa <= sb);
            OP_SGT:  y = WordW'(sa > sb);
            OP_SGE:  y = WordW'(sa >= sb);
            default: y = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/ifed_div.sv =====
`default_nettype none
module ifed_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_v,
    input  wire ifed_pkg::side_t            in_side,
    input  wire logic [ifed_pkg::WordW-1:0] dividend,
    input  wire logic [ifed_pkg::WordW-1:0] divisor,
    output logic                            out_v,
    output ifed_pkg::side_t                 out_side,
    output logic      [ifed_pkg::WordW-1:0] quo,
    output logic      [ifed_pkg::WordW-1:0] rem
);
    import ifed_pkg::*;

    localparam int unsigned N = WordW;

    logic             v_reg    [N+1];
    side_t            side_reg [N+1];
    logic [WordW-1:0] rem_reg  [N+1];
    logic [WordW-1:0] quo_reg  [N+1];
    logic [WordW-1:0] d_reg    [N+1];

    // Stage zero loads the operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= dividend;
            d_reg[0]    <= divisor;
        end
    end

    // One restoring step per stage, one quotient bit each
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [WordW:0] t;
        logic [WordW:0] diff;

        assign t    = {rem_reg[i], quo_reg[i][WordW-1]};
        assign diff = t - {1'b0, d_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                d_reg[i+1]    <= d_reg[i];
                if (!diff[WordW])
                begin
                    rem_reg[i+1] <= diff[WordW-1:0];
                    quo_reg[i+1] <= {quo_reg[i][WordW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= t[WordW-1:0];
                    quo_reg[i+1] <= {quo_reg[i][WordW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_v    = v_reg[N];
    assign out_side = side_reg[N];
    assign quo      = quo_reg[N];
    assign rem      = rem_reg[N];

endmodule
`default_nettype wire

// ===== rtl/core/integer_alu_fold_evaluator_top.sv =====
// Throughput: one beat per cycle while the output is not stalled; the 32-stage
// restoring divider, one quotient bit per stage, sets the depth and every stage
// advances together.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; no payload reset.
`default_nettype none
module integer_alu_fold_evaluator_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ifed_pkg::OpW-1:0]   operation,
    input  wire logic [ifed_pkg::WordW-1:0] left_value,
    input  wire logic [ifed_pkg::WordW-1:0] right_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [ifed_pkg::WordW-1:0] result
);
    import ifed_pkg::*;

    logic             adv;
    logic             a_v_reg;
    logic [OpW-1:0]   a_op_reg;
    logic [WordW-1:0] a_l_reg;
    logic [WordW-1:0] a_r_reg;
    logic             b_v_reg;
    side_t            b_side_reg;
    logic [WordW-1:0] b_num_reg;
    logic [WordW-1:0] b_den_reg;
    logic [WordW-1:0] fast;
    logic             d_v;
    side_t            d_side;
    logic [WordW-1:0] d_quo;
    logic [WordW-1:0] d_rem;
    logic             o_v_reg;
    logic [WordW-1:0] o_res_reg;
    logic [OpW-1:0]   o_op_reg;
    logic             o_dz_reg;
    logic [WordW-1:0] res_next;

    // Advance all stages when the output slot is free or being taken
    assign adv      = !o_v_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            o_v_reg <= d_v;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg <= operation;
            a_l_reg  <= left_value;
            a_r_reg  <= right_value;
        end
    end

    ifed_fast u_fast (
        .op (a_op_reg),
        .a  (a_l_reg),
        .b  (a_r_reg),
        .y  (fast)
    );

    // Register fast result, operand magnitudes and sign fixups
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_side_reg.op   <= a_op_reg;
            b_side_reg.fast <= fast;
            b_side_reg.qneg <= a_l_reg[WordW-1] ^ a_r_reg[WordW-1];
            b_side_reg.rneg <= a_l_reg[WordW-1];
            b_side_reg.dz   <= (a_r_reg == '0);
            b_num_reg       <= a_l_reg[WordW-1] ? (~a_l_reg + 1'b1) : a_l_reg;
            b_den_reg       <= a_r_reg[WordW-1] ? (~a_r_reg + 1'b1) : a_r_reg;
        end
    end

    ifed_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_v     (b_v_reg),
        .in_side  (b_side_reg),
        .dividend (b_num_reg),
        .divisor  (b_den_reg),
        .out_v    (d_v),
        .out_side (d_side),
        .quo      (d_quo),
        .rem      (d_rem)
    );

    // Pick the final value and apply the sign of quotient or remainder
    always_comb
    begin
        case (d_side.op)
            OP_DIV:
            begin
                if (d_side.dz)
                    res_next = '0;
                else
                    res_next = d_side.qneg ? (~d_quo + 1'b1) : d_quo;
            end
            OP_REM:
            begin
                if (d_side.dz)
                    res_next = '0;
                else
                    res_next = d_side.rneg ? (~d_rem + 1'b1) : d_rem;
            end
            default: res_next = d_side.fast;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_res_reg <= res_next;
            o_op_reg  <= d_side.op;
            o_dz_reg  <= d_side.dz;
        end
    end

    assign out_valid = o_v_reg;
    assign result    = o_res_reg;

    // Comparisons give only 0 or 1
    a_cmp : assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && (o_op_reg >= OP_EQ) && (o_op_reg <= OP_SGE)
        |-> (o_res_reg[WordW-1:1] == '0))
        else $error("comparison result wider than one bit");

    // Divide or remainder by zero gives zero
    a_dz : assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && o_dz_reg && ((o_op_reg == OP_DIV) || (o_op_reg == OP_REM))
        |-> (o_res_reg == '0))
        else $error("division by zero result not zero");

    // Unused codes give zero
    a_unused : assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && (o_op_reg > OP_REM) |-> (o_res_reg == '0))
        else $error("unused operation code gave nonzero result");

    // A stalled result holds its value
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && !out_ready |=> o_v_reg && $stable(o_res_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire
